[rtl/sjis_ckc_pkg.sv]
`default_nettype none
package sjis_ckc_pkg;

  localparam int ModeW   = 7;
  localparam int ByteW   = 8;
  localparam int FifoDepth = 8;
  localparam int FifoAw  = $clog2(FifoDepth);
  localparam int FifoCw  = FifoAw + 1;

  // mode_flags bit positions
  localparam int MB_A_UP  = 0;
  localparam int MB_A_LOW = 1;
  localparam int MB_W_UP  = 2;
  localparam int MB_W_LOW = 3;
  localparam int MB_KATA  = 4;
  localparam int MB_HIRA  = 5;
  localparam int MB_SPACE = 6;

  localparam logic [7:0] WIDE_OFS = 8'h81 - 8'h60;
  localparam logic [7:0] KANA_OFS = 8'h9f - 8'h40;
  localparam logic [7:0] SPACE_CH = 8'h20;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } res_t;

  function automatic logic is_lead(input logic [7:0] b);
    is_lead = (b >= 8'h81 && b <= 8'h9f) || (b >= 8'he0 && b <= 8'hfc);
  endfunction

  function automatic logic [7:0] conv_single(input logic [7:0] c,
                                             input logic [ModeW-1:0] mode);
    conv_single = c;
    if (c >= 8'h41 && c <= 8'h5a && mode[MB_A_LOW]) begin
      conv_single = c + 8'h20;
    end else if (c >= 8'h61 && c <= 8'h7a && mode[MB_A_UP]) begin
      conv_single = c - 8'h20;
    end
  endfunction

  // returns {lead, trail}
  function automatic logic [15:0] conv_pair(input logic [7:0] c, input logic [7:0] d,
                                            input logic [ModeW-1:0] mode);
    logic [7:0] oc;
    logic [7:0] od;
    logic [7:0] k;
    logic [7:0] h;
    oc = c;
    od = d;
    k  = d - KANA_OFS;
    h  = d;
    if (k > 8'h7e) k = k + 8'h01;
    if (h > 8'h7e) h = h - 8'h01;
    if (c == 8'h81) begin
      if (d == 8'h40 && mode[MB_SPACE]) begin
        oc = SPACE_CH;
        od = SPACE_CH;
      end
    end else if (c == 8'h82) begin
      if (d >= 8'h60 && d <= 8'h79) begin
        if (mode[MB_W_LOW]) od = d + WIDE_OFS;
      end else if (d >= 8'h81 && d <= 8'h9a) begin
        if (mode[MB_W_UP]) od = d - WIDE_OFS;
      end else if (d >= 8'h9f && d <= 8'hf1) begin
        if (mode[MB_KATA]) begin
          oc = 8'h83;
          od = k;
        end
      end
    end else if (c == 8'h83 && d >= 8'h40 && d <= 8'h93) begin
      if (mode[MB_HIRA]) begin
        oc = 8'h82;
        od = h + KANA_OFS;
      end
    end
    conv_pair = {oc, od};
  endfunction

endpackage
`default_nettype wire

[rtl/sjis_case_kana_converter_core.sv]
// channel  | dir | handshake          | payload
// ---------+-----+--------------------+------------------------------------
// s        | in  | s_tvalid/s_tready  | s_tdata[7:0] = in_byte
// m        | out | m_tvalid/m_tready  | m_tdata[7:0] = out_byte, m_tlast = last_of_run
// cfg      | in  | cfg_wr_en          | cfg_wr_data[6:0] = mode_flags
//
// one input byte per cycle while s_tready is high; the byte is held in the input register and its
// zero, one or two results land in an 8-entry result queue in the following cycle.
// first result becomes visible once it has passed the input register and been written into the queue.
// rst (synchronous) clears mode_flags, the held lead and the queue.
// s_tready drops only when the queue could not take two more results per byte in flight;
// a stalled m side fills the queue, it never loses or repeats results.
`default_nettype none
module sjis_case_kana_converter_core
  import sjis_ckc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,     // [7:0] in_byte
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [7:0]            m_tdata,     // [7:0] out_byte
  output logic                  m_tlast,     // last_of_run
  input  wire logic             cfg_wr_en,
  input  wire logic [ModeW-1:0] cfg_wr_data  // [6:0] mode_flags
);

  logic [ModeW-1:0]  mode;
  logic              stg_valid;
  logic [ByteW-1:0]  stg_byte;
  logic              lead_pending;
  logic              lead_pending_next;
  logic [ByteW-1:0]  held_lead;
  logic [ByteW-1:0]  held_lead_next;

  res_t              queue [FifoDepth];
  logic [FifoAw-1:0] wp;
  logic [FifoAw-1:0] rp;
  logic [FifoCw-1:0] cnt;
  logic [1:0]        push_cnt;
  res_t              ent0;
  res_t              ent1;
  logic              pop;
  logic [15:0]       pair;
  logic [FifoCw:0]   room_need;

  // room for the staged byte and the new one, two results each
  assign room_need = {1'b0, cnt} + (stg_valid ? (FifoCw+1)'(2) : '0);
  assign s_tready  = room_need <= (FifoCw+1)'(FifoDepth - 2);
  assign m_tvalid  = cnt != '0;
  assign m_tdata   = queue[rp].data;
  assign m_tlast   = queue[rp].last;
  assign pop       = m_tvalid & m_tready;
  assign pair      = conv_pair(held_lead, stg_byte, mode);

  always_comb begin
    push_cnt          = 2'd0;
    ent0              = '{data: stg_byte, last: 1'b1};
    ent1              = '{data: pair[7:0], last: 1'b1};
    lead_pending_next = lead_pending;
    held_lead_next    = held_lead;
    if (stg_valid) begin
      if (lead_pending) begin
        lead_pending_next = 1'b0;
        held_lead_next    = '0;
        if (stg_byte == '0) begin
          // lead dropped, only the terminator goes out
          push_cnt = 2'd1;
        end else begin
          push_cnt = 2'd2;
          ent0     = '{data: pair[15:8], last: 1'b0};
        end
      end else if (stg_byte <= 8'h80) begin
        push_cnt = 2'd1;
        ent0     = '{data: conv_single(stg_byte, mode), last: 1'b1};
      end else if (is_lead(stg_byte)) begin
        lead_pending_next = 1'b1;
        held_lead_next    = stg_byte;
      end else begin
        push_cnt = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= '0;
      stg_valid    <= 1'b0;
      lead_pending <= 1'b0;
      held_lead    <= '0;
      wp           <= '0;
      rp           <= '0;
      cnt          <= '0;
    end else begin
      if (cfg_wr_en) mode <= cfg_wr_data;
      stg_valid    <= s_tvalid & s_tready;
      lead_pending <= lead_pending_next;
      held_lead    <= held_lead_next;
      wp           <= wp + FifoAw'(push_cnt);
      if (pop) rp  <= rp + FifoAw'(1);
      cnt          <= cnt + FifoCw'(push_cnt) - FifoCw'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) stg_byte <= s_tdata;
    if (push_cnt != 2'd0) queue[wp] <= ent0;
    if (push_cnt == 2'd2) queue[wp + FifoAw'(1)] <= ent1;
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= FifoCw'(FifoDepth))
    else $error("result queue overflow");

  a_cnt_ptr: assert property (@(posedge clk) disable iff (rst)
    cnt[FifoAw-1:0] == FifoAw'(wp - rp))
    else $error("queue count out of step with pointers");

  a_lead_held: assert property (@(posedge clk) disable iff (rst)
    lead_pending |-> held_lead != '0)
    else $error("pending lead with empty holder");

  a_pair_push: assert property (@(posedge clk) disable iff (rst)
    (stg_valid && lead_pending && stg_byte != '0) |=> !lead_pending)
    else $error("trail byte did not release the lead");
`endif

endmodule
`default_nettype wire
